[rtl/ccp_pkg.sv]
// Shared types, codes and lookup functions for the constant pool parser.
// Used by ccp_parse, ccp_out_buf and class_constant_pool_parser. No dependencies.
package ccp_pkg;

  localparam int unsigned KIND_W = 5;

  // Result codes.
  localparam logic [1:0] RK_ENTRY = 2'd0;
  localparam logic [1:0] RK_TEXT  = 2'd1;
  localparam logic [1:0] RK_ERROR = 2'd2;

  // Dense entry kinds that need special handling.
  localparam logic [KIND_W-1:0] KIND_UTF8   = 5'd0;
  localparam logic [KIND_W-1:0] KIND_LONG   = 5'd3;
  localparam logic [KIND_W-1:0] KIND_DOUBLE = 5'd4;
  localparam logic [KIND_W-1:0] KIND_NONE   = 5'd31;

  // Tag byte values from the class file format.
  localparam logic [7:0] TAG_UTF8        = 8'd1;
  localparam logic [7:0] TAG_INTEGER     = 8'd3;
  localparam logic [7:0] TAG_FLOAT       = 8'd4;
  localparam logic [7:0] TAG_LONG        = 8'd5;
  localparam logic [7:0] TAG_DOUBLE      = 8'd6;
  localparam logic [7:0] TAG_CLASS       = 8'd7;
  localparam logic [7:0] TAG_STRING      = 8'd8;
  localparam logic [7:0] TAG_FIELDREF    = 8'd9;
  localparam logic [7:0] TAG_METHODREF   = 8'd10;
  localparam logic [7:0] TAG_IMETHODREF  = 8'd11;
  localparam logic [7:0] TAG_NAMETYPE    = 8'd12;
  localparam logic [7:0] TAG_MHANDLE     = 8'd15;
  localparam logic [7:0] TAG_MTYPE       = 8'd16;
  localparam logic [7:0] TAG_DYNAMIC     = 8'd17;
  localparam logic [7:0] TAG_INVOKEDYN   = 8'd18;
  localparam logic [7:0] TAG_MODULE      = 8'd19;
  localparam logic [7:0] TAG_PACKAGE     = 8'd20;

  typedef enum logic [2:0] {
    FMT_LEN,
    FMT_RAW,
    FMT_ONE,
    FMT_TWO,
    FMT_HANDLE
  } fmt_t;

  typedef struct packed {
    logic [1:0]        result_kind;
    logic [KIND_W-1:0] entry_kind;
    logic [15:0]       slot_index;
    logic [63:0]       value_bits;
    logic [15:0]       second_index;
    logic [7:0]        handle_kind;
    logic [7:0]        text_byte;
    logic              last_text;
  } result_t;

  function automatic logic [KIND_W-1:0] tag_to_kind(input logic [7:0] tag);
    logic [KIND_W-1:0] k;
    case (tag)
      TAG_UTF8:       k = 5'd0;
      TAG_INTEGER:    k = 5'd1;
      TAG_FLOAT:      k = 5'd2;
      TAG_LONG:       k = 5'd3;
      TAG_DOUBLE:     k = 5'd4;
      TAG_CLASS:      k = 5'd5;
      TAG_STRING:     k = 5'd6;
      TAG_FIELDREF:   k = 5'd7;
      TAG_METHODREF:  k = 5'd8;
      TAG_IMETHODREF: k = 5'd9;
      TAG_NAMETYPE:   k = 5'd10;
      TAG_MHANDLE:    k = 5'd11;
      TAG_MTYPE:      k = 5'd12;
      TAG_DYNAMIC:    k = 5'd13;
      TAG_INVOKEDYN:  k = 5'd14;
      TAG_MODULE:     k = 5'd15;
      TAG_PACKAGE:    k = 5'd16;
      default:        k = KIND_NONE;
    endcase
    return k;
  endfunction

  // Number of field bytes that follow the tag.
  function automatic logic [3:0] kind_bytes(input logic [KIND_W-1:0] k);
    logic [3:0] n;
    case (k)
      5'd1, 5'd2, 5'd7, 5'd8, 5'd9, 5'd10, 5'd13, 5'd14: n = 4'd4;
      5'd3, 5'd4:                                        n = 4'd8;
      5'd11:                                             n = 4'd3;
      default:                                           n = 4'd2;
    endcase
    return n;
  endfunction

  function automatic fmt_t kind_fmt(input logic [KIND_W-1:0] k);
    fmt_t f;
    case (k)
      5'd0:                             f = FMT_LEN;
      5'd1, 5'd2, 5'd3, 5'd4:           f = FMT_RAW;
      5'd7, 5'd8, 5'd9, 5'd10, 5'd13,
      5'd14:                            f = FMT_TWO;
      5'd11:                            f = FMT_HANDLE;
      default:                          f = FMT_ONE;
    endcase
    return f;
  endfunction

endpackage

[rtl/ccp_parse.sv]
// Byte-level parse state machine for the constant pool stream.
// Depends on ccp_pkg for kind tables and the result struct.
module ccp_parse (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        data_byte,
  input  logic              pool_start,
  output logic              res_valid,
  output ccp_pkg::result_t  res
);

  typedef enum logic [1:0] {
    PH_TAG,
    PH_FIELDS,
    PH_TEXT
  } phase_t;

  phase_t                    phase, phase_next;
  logic [ccp_pkg::KIND_W-1:0] cur_kind, cur_kind_next;
  logic [3:0]                cnt, cnt_next;
  logic [63:0]               acc, acc_next;
  logic [15:0]               first_idx, first_idx_next;
  logic [7:0]                hkind, hkind_next;
  logic [15:0]               text_rem, text_rem_next;
  logic [15:0]               slot, slot_next;

  always_comb begin
    phase_t                     ph;
    logic [15:0]                slot_cur;
    logic [ccp_pkg::KIND_W-1:0] k;
    ccp_pkg::fmt_t              fmt;
    logic [1:0]                 adv;
    logic [16:0]                sum;

    phase_next     = phase;
    cur_kind_next  = cur_kind;
    cnt_next       = cnt;
    acc_next       = acc;
    first_idx_next = first_idx;
    hkind_next     = hkind;
    text_rem_next  = text_rem;
    res_valid      = 1'b0;
    res            = '0;
    adv            = 2'd0;

    // A pool start drops any partial entry and restarts slot numbering.
    ph       = pool_start ? PH_TAG : phase;
    slot_cur = pool_start ? 16'd1 : slot;
    fmt      = ccp_pkg::kind_fmt(cur_kind);
    k        = ccp_pkg::tag_to_kind(data_byte);

    res.slot_index = slot_cur;

    unique case (ph)
      PH_TEXT: begin
        res_valid       = 1'b1;
        res.result_kind = ccp_pkg::RK_TEXT;
        res.text_byte   = data_byte;
        text_rem_next   = text_rem - 16'd1;
        if (text_rem_next == 16'd0) begin
          res.last_text = 1'b1;
          adv           = 2'd1;
          phase_next    = PH_TAG;
        end else begin
          phase_next = PH_TEXT;
        end
      end
      PH_FIELDS: begin
        acc_next = {acc[55:0], data_byte};
        cnt_next = cnt + 4'd1;
        if (fmt == ccp_pkg::FMT_TWO && cnt_next == 4'd2) begin
          first_idx_next = acc_next[15:0];
        end
        if (fmt == ccp_pkg::FMT_HANDLE && cnt_next == 4'd1) begin
          hkind_next = data_byte;
        end
        phase_next = PH_FIELDS;
        if (cnt_next == ccp_pkg::kind_bytes(cur_kind)) begin
          res_valid       = 1'b1;
          res.result_kind = ccp_pkg::RK_ENTRY;
          res.entry_kind  = cur_kind;
          unique case (fmt)
            ccp_pkg::FMT_RAW: begin
              if (cnt_next == 4'd4) begin
                res.value_bits = {32'd0, acc_next[31:0]};
              end else begin
                res.value_bits = acc_next;
              end
            end
            ccp_pkg::FMT_TWO: begin
              res.value_bits   = {48'd0, first_idx};
              res.second_index = acc_next[15:0];
            end
            ccp_pkg::FMT_HANDLE: begin
              res.value_bits  = {48'd0, acc_next[15:0]};
              res.handle_kind = hkind;
            end
            default: begin
              res.value_bits = {48'd0, acc_next[15:0]};
            end
          endcase
          phase_next = PH_TAG;
          if (fmt == ccp_pkg::FMT_LEN && acc_next[15:0] != 16'd0) begin
            text_rem_next = acc_next[15:0];
            phase_next    = PH_TEXT;
          end else if (cur_kind == ccp_pkg::KIND_LONG ||
                       cur_kind == ccp_pkg::KIND_DOUBLE) begin
            adv = 2'd2;
          end else begin
            adv = 2'd1;
          end
        end
      end
      default: begin
        if (k == ccp_pkg::KIND_NONE) begin
          res_valid       = 1'b1;
          res.result_kind = ccp_pkg::RK_ERROR;
          res.value_bits  = {56'd0, data_byte};
          adv             = 2'd1;
          phase_next      = PH_TAG;
        end else begin
          cur_kind_next  = k;
          cnt_next       = 4'd0;
          acc_next       = '0;
          first_idx_next = '0;
          hkind_next     = '0;
          phase_next     = PH_FIELDS;
        end
      end
    endcase

    // The slot counter saturates at its top value.
    sum       = {1'b0, slot_cur} + {15'd0, adv};
    slot_next = sum[16] ? 16'hFFFF : sum[15:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_TAG;
      cur_kind  <= '0;
      cnt       <= '0;
      acc       <= '0;
      first_idx <= '0;
      hkind     <= '0;
      text_rem  <= '0;
      slot      <= 16'd1;
    end else if (accept) begin
      phase     <= phase_next;
      cur_kind  <= cur_kind_next;
      cnt       <= cnt_next;
      acc       <= acc_next;
      first_idx <= first_idx_next;
      hkind     <= hkind_next;
      text_rem  <= text_rem_next;
      slot      <= slot_next;
    end
  end

endmodule

[rtl/ccp_out_buf.sv]
// Result register with a skid stage: a result is taken in even while the output register is
// stalled, and the input side is held off only while the skid entry is full.
// Depends on ccp_pkg for the result struct.
module ccp_out_buf (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  ccp_pkg::result_t push_data,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output ccp_pkg::result_t out_data
);

  logic             skid_valid;
  ccp_pkg::result_t skid_data;
  logic             pop;

  assign pop      = out_valid && out_ready;
  assign in_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_data <= skid_data;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        out_data <= push_data;
      end else begin
        skid_data <= push_data;
      end
    end
  end

endmodule

[rtl/class_constant_pool_parser.sv]
// Constant pool stream parser: one pool byte per item in, at most one result per item out.
// The block takes one byte in every cycle while its two-entry output stage has room; when the
// output stage is empty a result appears at the output the cycle after the byte that causes it,
// and the parse state machine updates in the same cycle it accepts a byte, so the sustained
// rate is one byte per cycle. Tag bytes and non-final field bytes give no result; the final
// field byte gives an entry result, each utf8 text byte gives a text result, and an unknown
// tag gives an error result. Depends on ccp_pkg, ccp_parse and ccp_out_buf.
module class_constant_pool_parser (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // [7:0] data_byte
  input  logic [0:0]   s_tuser,   // [0] pool_start
  output logic         m_tvalid,
  input  logic         m_tready,
  // [15:0] slot_index, [79:16] value_bits, [95:80] second_index,
  // [103:96] handle_kind, [111:104] text_byte
  output logic [111:0] m_tdata,
  output logic [6:0]   m_tuser,   // [1:0] result_kind, [6:2] entry_kind
  output logic         m_tlast    // last_text
);

  logic             accept;
  logic             res_valid;
  ccp_pkg::result_t res;
  ccp_pkg::result_t out_res;

  assign accept = s_tvalid && s_tready;

  ccp_parse u_parse (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .data_byte  (s_tdata),
    .pool_start (s_tuser[0]),
    .res_valid  (res_valid),
    .res        (res)
  );

  ccp_out_buf u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (accept && res_valid),
    .push_data (res),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_res)
  );

  assign m_tdata = {out_res.text_byte, out_res.handle_kind, out_res.second_index,
                    out_res.value_bits, out_res.slot_index};
  assign m_tuser = {out_res.entry_kind, out_res.result_kind};
  assign m_tlast = out_res.last_text;

  // The input side only stalls when both output entries are occupied.
  a_stall_has_output: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled with no pending output");

  a_last_is_text: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser[1:0] == ccp_pkg::RK_TEXT)
    else $error("last_text set on a non-text result");

  a_error_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1:0] == ccp_pkg::RK_ERROR |->
      m_tdata[111:80] == 32'd0 && m_tdata[79:24] == 56'd0 && m_tuser[6:2] == 5'd0)
    else $error("error result carries nonzero fields");

  a_slot_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[15:0] != 16'd0)
    else $error("result slot index is zero");

endmodule
